@@ rtl/ica_pkg.sv @@
// Shared types, constants and helpers for the interrupt claim arbiter.
// No dependencies; every other file in rtl/ references this package by scope.
package ica_pkg;

    localparam int NUM_SOURCES = 63;
    localparam int NUM_TARGETS = 4;

    localparam int SID_W  = 6;
    localparam int TGT_W  = 2;
    localparam int VAL_W  = 64;
    localparam int PRIO_W = 3;
    localparam int THR_W  = 8;
    localparam int REQ_W  = 3;

    localparam int NUM_IDS = 1 << SID_W;

    localparam logic [SID_W-1:0] LAST_ID = SID_W'(NUM_SOURCES);

    localparam logic [REQ_W-1:0] REQ_RAISE    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_CLAIM    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_COMPLETE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SET_PRIO = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SET_EN   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_SET_THR  = 3'd5;

    typedef enum logic [2:0] {
        OP_RAISE,
        OP_CLAIM,
        OP_COMPLETE,
        OP_SET_PRIO,
        OP_SET_EN,
        OP_SET_THR,
        OP_REJECT
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [SID_W-1:0] sid;
        logic [TGT_W-1:0] tgt;
        logic [VAL_W-1:0] val;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_back_state;

    // Bits 1..NUM_SOURCES set: the sources that exist.
    function automatic logic [VAL_W-1:0] source_mask();
        logic [VAL_W-1:0] m;
        for (int i = 0; i < VAL_W; i++) begin
            m[i] = (i >= 1) && (i <= NUM_SOURCES);
        end
        return m;
    endfunction

endpackage

@@ rtl/ica_front.sv @@
// Front end: accepts request items and classifies them into commands.
// Depends on ica_pkg.
module ica_front (
    input  logic                        i_start,
    input  logic                        i_full,
    input  logic [ica_pkg::REQ_W-1:0]   i_req_type,
    input  logic [ica_pkg::SID_W-1:0]   i_source_id,
    input  logic [ica_pkg::TGT_W-1:0]   i_target_index,
    input  logic [ica_pkg::VAL_W-1:0]   i_write_value,
    output logic                        o_push,
    output ica_pkg::t_cmd               o_cmd
);

    logic w_src_ok;
    logic w_tgt_ok;

    assign w_src_ok = (i_source_id != '0) && (int'(i_source_id) <= ica_pkg::NUM_SOURCES);
    assign w_tgt_ok = int'(i_target_index) < ica_pkg::NUM_TARGETS;
    assign o_push   = i_start && !i_full;

    always_comb begin
        o_cmd.sid = i_source_id;
        o_cmd.tgt = i_target_index;
        o_cmd.val = i_write_value;
        case (i_req_type)
            ica_pkg::REQ_RAISE:    o_cmd.op = w_src_ok ? ica_pkg::OP_RAISE : ica_pkg::OP_REJECT;
            ica_pkg::REQ_CLAIM:    o_cmd.op = w_tgt_ok ? ica_pkg::OP_CLAIM : ica_pkg::OP_REJECT;
            ica_pkg::REQ_COMPLETE: o_cmd.op = (w_src_ok && w_tgt_ok) ? ica_pkg::OP_COMPLETE
                                                                     : ica_pkg::OP_REJECT;
            ica_pkg::REQ_SET_PRIO: o_cmd.op = w_src_ok ? ica_pkg::OP_SET_PRIO
                                                       : ica_pkg::OP_REJECT;
            ica_pkg::REQ_SET_EN:   o_cmd.op = w_tgt_ok ? ica_pkg::OP_SET_EN : ica_pkg::OP_REJECT;
            ica_pkg::REQ_SET_THR:  o_cmd.op = w_tgt_ok ? ica_pkg::OP_SET_THR : ica_pkg::OP_REJECT;
            default:               o_cmd.op = ica_pkg::OP_REJECT;
        endcase
    end

endmodule

@@ rtl/ica_fifo.sv @@
// Two-entry command queue between the front end and the back end.
// Depends on ica_pkg for the command type.
module ica_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ica_pkg::t_cmd i_data,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output ica_pkg::t_cmd o_data
);

    ica_pkg::t_cmd r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic          n_wr_ptr;
    logic          n_rd_ptr;
    logic [1:0]    n_count;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ rtl/ica_back.sv @@
// Back end: holds pending, priority, enable and threshold state and executes
// commands; a claim scans one source per cycle. Depends on ica_pkg.
module ica_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    input  ica_pkg::t_cmd             i_cmd,
    output logic                      o_pop,
    output logic                      o_valid,
    output logic [ica_pkg::SID_W-1:0] o_claim_id,
    output logic                      o_rejected
);

    localparam int SW = ica_pkg::SID_W;
    localparam int VW = ica_pkg::VAL_W;
    localparam int PW = ica_pkg::PRIO_W;
    localparam int TW = ica_pkg::THR_W;

    ica_pkg::t_back_state r_state, n_state;

    logic [VW-1:0]    r_pending, n_pending;
    logic [VW-1:0]    r_enable [ica_pkg::NUM_TARGETS];
    logic [TW-1:0]    r_thresh [ica_pkg::NUM_TARGETS];
    logic [PW-1:0]    r_prio_mem [ica_pkg::NUM_IDS];
    logic [ica_pkg::NUM_IDS-1:0] r_prio_vld;

    logic [ica_pkg::TGT_W-1:0] r_tgt, n_tgt;
    logic [SW-1:0]    r_addr, n_addr;
    logic             r_stg_vld;
    logic [SW-1:0]    r_stg_id;
    logic [PW-1:0]    r_stg_prio;
    logic             r_stg_pv;
    logic             r_stg_cand;
    logic [SW-1:0]    r_best_id, n_best_id;
    logic [PW-1:0]    r_best_pri, n_best_pri;
    logic             r_valid, n_valid;
    logic [SW-1:0]    r_claim, n_claim;
    logic             r_rej, n_rej;

    logic             w_exec;
    logic             w_hit;
    logic [PW-1:0]    w_stg_prio;
    logic [SW-1:0]    w_win_id;
    logic [PW-1:0]    w_win_pri;

    assign w_exec = (r_state == ica_pkg::ST_IDLE) && i_cmd_valid;
    assign o_pop  = w_exec;

    // Entries never written read as priority zero.
    assign w_stg_prio = r_stg_pv ? r_stg_prio : '0;
    assign w_hit = r_stg_vld && r_stg_cand && (w_stg_prio != '0)
                && ({{(TW-PW){1'b0}}, w_stg_prio} >= r_thresh[r_tgt])
                && (w_stg_prio > r_best_pri);
    assign w_win_id  = w_hit ? r_stg_id   : r_best_id;
    assign w_win_pri = w_hit ? w_stg_prio : r_best_pri;

    assign o_valid    = r_valid;
    assign o_claim_id = r_claim;
    assign o_rejected = r_rej;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ica_pkg::ST_IDLE:  if (w_exec && i_cmd.op == ica_pkg::OP_CLAIM) n_state = ica_pkg::ST_SCAN;
            ica_pkg::ST_SCAN:  if (r_addr == ica_pkg::LAST_ID) n_state = ica_pkg::ST_DRAIN;
            ica_pkg::ST_DRAIN: n_state = ica_pkg::ST_IDLE;
            default:           n_state = ica_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_pending  = r_pending;
        n_tgt      = r_tgt;
        n_addr     = r_addr;
        n_best_id  = r_best_id;
        n_best_pri = r_best_pri;
        n_valid    = 1'b0;
        n_claim    = '0;
        n_rej      = 1'b0;
        case (r_state)
            ica_pkg::ST_IDLE: begin
                if (w_exec) begin
                    n_valid = i_cmd.op != ica_pkg::OP_CLAIM;
                    n_rej   = i_cmd.op == ica_pkg::OP_REJECT;
                    case (i_cmd.op)
                        ica_pkg::OP_RAISE:    n_pending[i_cmd.sid] = 1'b1;
                        ica_pkg::OP_COMPLETE: n_pending[i_cmd.sid] = 1'b0;
                        ica_pkg::OP_CLAIM: begin
                            n_tgt      = i_cmd.tgt;
                            n_addr     = SW'(1);
                            n_best_id  = '0;
                            n_best_pri = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ica_pkg::ST_SCAN: begin
                n_addr     = r_addr + SW'(1);
                n_best_id  = w_win_id;
                n_best_pri = w_win_pri;
            end
            ica_pkg::ST_DRAIN: begin
                n_valid = 1'b1;
                n_claim = w_win_id;
                if (w_win_id != '0) begin
                    n_pending[w_win_id] = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Priority store: write on set-priority, read one source per scan cycle.
    always_ff @(posedge i_clk) begin
        if (w_exec && i_cmd.op == ica_pkg::OP_SET_PRIO) begin
            r_prio_mem[i_cmd.sid] <= i_cmd.val[PW-1:0];
        end
        r_stg_prio <= r_prio_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        r_stg_id   <= r_addr;
        r_stg_pv   <= r_prio_vld[r_addr];
        r_stg_cand <= r_pending[r_addr] && r_enable[r_tgt][r_addr];
        r_tgt      <= n_tgt;
        r_addr     <= n_addr;
        r_best_id  <= n_best_id;
        r_best_pri <= n_best_pri;
        r_claim    <= n_claim;
        r_rej      <= n_rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ica_pkg::ST_IDLE;
            r_pending  <= '0;
            r_prio_vld <= '0;
            r_stg_vld  <= 1'b0;
            r_valid    <= 1'b0;
            for (int t = 0; t < ica_pkg::NUM_TARGETS; t++) begin
                r_enable[t] <= '0;
                r_thresh[t] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_stg_vld <= r_state == ica_pkg::ST_SCAN;
            r_valid   <= n_valid;
            if (w_exec && i_cmd.op == ica_pkg::OP_SET_PRIO) begin
                r_prio_vld[i_cmd.sid] <= 1'b1;
            end
            if (w_exec && i_cmd.op == ica_pkg::OP_SET_EN) begin
                r_enable[i_cmd.tgt] <= i_cmd.val & ica_pkg::source_mask();
            end
            if (w_exec && i_cmd.op == ica_pkg::OP_SET_THR) begin
                r_thresh[i_cmd.tgt] <= i_cmd.val[TW-1:0];
            end
        end
    end

endmodule

@@ rtl/interrupt_claim_arbiter.sv @@
// Interrupt claim arbiter: front end, two-entry command queue and back end.
// Depends on ica_pkg, ica_front, ica_fifo and ica_back.
// Timing: a raise, complete, write or rejected item passes the queue register
// and the back-end output register before its result shows; a claim is dequeued,
// scans the priority store one source per cycle, then drains to the output register.
// The back end takes no new item while a claim scans or drains; other items
// are taken one per cycle while no claim is in progress.
// Reset (synchronous, active low) clears pending bits, priorities, enables,
// thresholds and the queue; o_valid is a one-cycle strobe the receiver cannot stall.
module interrupt_claim_arbiter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ica_pkg::REQ_W-1:0]   i_req_type,
    input  logic [ica_pkg::SID_W-1:0]   i_source_id,
    input  logic [ica_pkg::TGT_W-1:0]   i_target_index,
    input  logic [ica_pkg::VAL_W-1:0]   i_write_value,
    output logic                        o_valid,
    output logic [ica_pkg::SID_W-1:0]   o_claim_id,
    output logic                        o_rejected
);

    logic          w_push;
    logic          w_full;
    logic          w_pop;
    logic          w_cmd_valid;
    ica_pkg::t_cmd w_front_cmd;
    ica_pkg::t_cmd w_back_cmd;

    // Hold off new items only when the queue is full.
    assign busy = w_full;

    // Classify the request and check source and target ranges.
    ica_front u_front (
        .i_start        (start),
        .i_full         (w_full),
        .i_req_type     (i_req_type),
        .i_source_id    (i_source_id),
        .i_target_index (i_target_index),
        .i_write_value  (i_write_value),
        .o_push         (w_push),
        .o_cmd          (w_front_cmd)
    );

    // Decouple acceptance from execution so the front keeps taking items
    // while a claim scan is in progress.
    ica_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_cmd_valid),
        .o_data  (w_back_cmd)
    );

    // Execute commands against the interrupt state; arbitrate claims.
    ica_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_back_cmd),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .o_claim_id  (o_claim_id),
        .o_rejected  (o_rejected)
    );

endmodule
